/* hdl/lav_pkg.sv */
package lav_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int CW          = 32;
    localparam int MINW        = 17;
    localparam int DW          = CW + 2;
    localparam int VW          = 36;
    localparam int UW          = FRAC_BITS + 2;
    localparam int BW          = CW + 1;
    localparam int PW          = VW + BW;
    localparam int SW          = PW + 2;
    localparam int MAGW        = CW - 1;
    localparam int SQW         = 2 * MAGW + 2;
    localparam int LENW        = SQW / 2;
    localparam int QW          = FRAC_BITS + 1;
    localparam int NW          = MAGW + FRAC_BITS + 1;
    localparam int USERW       = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [MINW-1:0] MIN_LEN_RST = MINW'(1);
    localparam logic [1:0]      ROW_TRANS   = 2'd3;

    typedef logic signed [VW-1:0] t_vec [3];
    typedef logic signed [UW-1:0] t_unit [3];

    typedef struct packed {
        logic [2:0][CW-1:0] eye;
        logic [2:0][CW-1:0] up;
        logic [2:0][DW-1:0] dir;
    } t_item;

    typedef struct packed {
        logic done;
        logic ok;
    } t_norm_sts;

    typedef enum logic [2:0] {
        N_IDLE, N_SQ, N_ROOT, N_CHK, N_DSET, N_DIV
    } t_norm_state;

    typedef enum logic [2:0] {
        B_IDLE, B_NF_GO, B_NF_WAIT, B_MAC, B_NU_GO, B_NU_WAIT, B_EMIT, B_ERR
    } t_back_state;

    typedef enum logic [1:0] {
        J_DOT, J_W, J_CROSS, J_TRANS
    } t_job;

    typedef enum logic [1:0] {
        T_WORLD, T_AXIS_Y, T_AXIS_Z
    } t_try;

endpackage

/* hdl/lav_front.sv */
module lav_front #(
    parameter int DEPTH = lav_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [9*lav_pkg::CW-1:0]  i_data,
    input  logic                      i_pop,
    output logic                      o_avail,
    output lav_pkg::t_item            o_item
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    lav_pkg::t_item r_mem [DEPTH];
    lav_pkg::t_item w_item;
    logic [PTRW-1:0] r_wr, r_rd;
    logic [CNTW-1:0] r_count;
    logic            w_push, w_pop;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_item.eye[k] = i_data[k*lav_pkg::CW +: lav_pkg::CW];
            w_item.up[k]  = i_data[(6+k)*lav_pkg::CW +: lav_pkg::CW];
            w_item.dir[k] = lav_pkg::DW'($signed(i_data[(3+k)*lav_pkg::CW +: lav_pkg::CW]))
                          - lav_pkg::DW'($signed(i_data[k*lav_pkg::CW +: lav_pkg::CW]));
        end
    end

    assign o_ready = (r_count != CNTW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_avail;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/lav_norm.sv */
module lav_norm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  lav_pkg::t_vec               i_vec,
    input  logic [lav_pkg::MINW-1:0]    i_min_len,
    output lav_pkg::t_norm_sts          o_sts,
    output lav_pkg::t_unit              o_vec
);

    localparam int IW = $clog2(lav_pkg::QW);

    lav_pkg::t_norm_state r_state, n_state;

    logic [lav_pkg::VW-1:0]    w_abs [3];
    logic [lav_pkg::VW-1:0]    w_max;
    logic [2:0]                w_sh;
    logic [lav_pkg::LENW-1:0]  w_len;
    logic                      w_bad;
    logic [lav_pkg::NW-1:0]    w_num;
    logic [lav_pkg::LENW:0]    w_trial;
    logic                      w_qbit;
    logic [lav_pkg::QW-1:0]    w_quot;
    logic                      w_root_last, w_div_last;

    logic                      r_neg [3];
    logic [lav_pkg::MAGW-1:0]  r_mag [3];
    logic                      r_s0;
    logic [1:0]                r_k;
    logic                      r_pv;
    logic [2*lav_pkg::MAGW-1:0] r_prod;
    logic [lav_pkg::SQW-1:0]   r_sum, r_res, r_bit;
    logic [lav_pkg::LENW-1:0]  r_len, r_rem;
    logic [lav_pkg::QW-1:0]    r_nlo;
    logic [IW-1:0]             r_i;
    logic [1:0]                r_c;
    lav_pkg::t_unit            r_u;
    logic                      r_done, r_ok;

    always_comb begin
        w_max = '0;
        w_sh  = '0;
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = i_vec[k][lav_pkg::VW-1] ? lav_pkg::VW'(-i_vec[k])
                                               : lav_pkg::VW'(i_vec[k]);
            if (w_abs[k] > w_max) begin
                w_max = w_abs[k];
            end
        end
        for (int b = lav_pkg::MAGW; b < lav_pkg::VW; b++) begin
            if (w_max[b]) begin
                w_sh = 3'(b - lav_pkg::MAGW + 1);
            end
        end
    end

    assign w_len   = r_res[lav_pkg::LENW-1:0];
    assign w_bad   = (w_len == '0) || (r_s0 && (w_len < lav_pkg::LENW'(i_min_len)));
    assign w_num   = (lav_pkg::NW'(r_mag[r_c]) << lav_pkg::FRAC_BITS)
                   + lav_pkg::NW'(r_len >> 1);
    assign w_trial = {r_rem, r_nlo[lav_pkg::QW-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_len});
    assign w_quot  = {r_nlo[lav_pkg::QW-2:0], w_qbit};
    assign w_root_last = (r_bit == lav_pkg::SQW'(1));
    assign w_div_last  = (r_i == IW'(lav_pkg::QW - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lav_pkg::N_IDLE: if (i_start) n_state = lav_pkg::N_SQ;
            lav_pkg::N_SQ:   if (r_k == 2'd3) n_state = lav_pkg::N_ROOT;
            lav_pkg::N_ROOT: if (w_root_last) n_state = lav_pkg::N_CHK;
            lav_pkg::N_CHK:  n_state = w_bad ? lav_pkg::N_IDLE : lav_pkg::N_DSET;
            lav_pkg::N_DSET: n_state = lav_pkg::N_DIV;
            lav_pkg::N_DIV: begin
                if (w_div_last) begin
                    n_state = (r_c == 2'd2) ? lav_pkg::N_IDLE : lav_pkg::N_DSET;
                end
            end
            default: n_state = lav_pkg::N_IDLE;
        endcase
    end

    always_comb begin
        o_sts.done = r_done;
        o_sts.ok   = r_ok;
        o_vec      = r_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lav_pkg::N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == lav_pkg::N_CHK) && w_bad)
                    || ((r_state == lav_pkg::N_DIV) && w_div_last && (r_c == 2'd2));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lav_pkg::N_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= i_vec[k][lav_pkg::VW-1];
                    r_mag[k] <= lav_pkg::MAGW'(w_abs[k] >> w_sh);
                end
                r_s0  <= (w_sh == '0);
                r_k   <= '0;
                r_pv  <= 1'b0;
                r_sum <= '0;
            end
            lav_pkg::N_SQ: begin
                if (r_k != 2'd3) begin
                    r_prod <= r_mag[r_k] * r_mag[r_k];
                    r_k    <= r_k + 1'b1;
                end
                r_pv <= (r_k != 2'd3);
                if (r_pv) begin
                    r_sum <= r_sum + lav_pkg::SQW'(r_prod);
                end
                r_res <= '0;
                r_bit <= lav_pkg::SQW'(1) << (lav_pkg::SQW - 2);
            end
            lav_pkg::N_ROOT: begin
                if (r_sum >= r_res + r_bit) begin
                    r_sum <= r_sum - (r_res + r_bit);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            lav_pkg::N_CHK: begin
                r_ok  <= !w_bad;
                r_len <= w_len;
                r_c   <= '0;
            end
            lav_pkg::N_DSET: begin
                r_rem <= lav_pkg::LENW'(w_num >> lav_pkg::QW);
                r_nlo <= w_num[lav_pkg::QW-1:0];
                r_i   <= '0;
            end
            lav_pkg::N_DIV: begin
                r_rem <= w_qbit ? lav_pkg::LENW'(w_trial - {1'b0, r_len})
                                : lav_pkg::LENW'(w_trial);
                r_nlo <= w_quot;
                r_i   <= r_i + 1'b1;
                if (w_div_last) begin
                    r_u[r_c] <= r_neg[r_c] ? -lav_pkg::UW'(w_quot) : lav_pkg::UW'(w_quot);
                    r_c      <= r_c + 1'b1;
                end
            end
            default: begin
                r_k <= '0;
            end
        endcase
    end

endmodule

/* hdl/lav_back.sv */
module lav_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_avail,
    output logic                           o_pop,
    input  lav_pkg::t_item                 i_item,
    input  logic [lav_pkg::MINW-1:0]       i_min_len,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [3*lav_pkg::CW-1:0]       o_data,
    output logic [lav_pkg::USERW-1:0]      o_user,
    output logic                           o_last
);

    localparam logic signed [lav_pkg::SW-1:0] HALF  = lav_pkg::SW'(2**(lav_pkg::FRAC_BITS-1));
    localparam logic signed [lav_pkg::SW-1:0] ONE   = lav_pkg::SW'(2**lav_pkg::FRAC_BITS);
    localparam logic signed [lav_pkg::SW-1:0] SAT_HI =
        {{(lav_pkg::SW-lav_pkg::CW+1){1'b0}}, {(lav_pkg::CW-1){1'b1}}};
    localparam logic signed [lav_pkg::SW-1:0] SAT_LO =
        {{(lav_pkg::SW-lav_pkg::CW+1){1'b1}}, {(lav_pkg::CW-1){1'b0}}};

    function automatic logic signed [lav_pkg::CW-1:0] sat32(input logic signed [lav_pkg::SW-1:0] v);
        logic signed [lav_pkg::CW-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[lav_pkg::CW-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[lav_pkg::CW-1:0];
        end else begin
            res = v[lav_pkg::CW-1:0];
        end
        return res;
    endfunction

    lav_pkg::t_back_state r_state, n_state;
    lav_pkg::t_job        r_job;
    lav_pkg::t_try        r_try;

    logic signed [lav_pkg::CW-1:0] r_eye [3];
    logic signed [lav_pkg::CW-1:0] r_up [3];
    lav_pkg::t_vec                 r_vec;
    lav_pkg::t_unit                r_f, r_u, w_nvec;
    logic signed [lav_pkg::VW-1:0] r_dot;
    logic signed [lav_pkg::CW-1:0] r_r [3];
    logic signed [lav_pkg::CW-1:0] r_t [3];
    lav_pkg::t_norm_sts            w_nsts;

    logic [1:0]                    r_j, r_k, r_pj;
    logic                          r_iss_done, r_pv, r_pfirst, r_plast;
    logic signed [lav_pkg::PW-1:0] r_prod;
    logic signed [lav_pkg::SW-1:0] r_acc, w_sum, w_rnd, w_base;
    logic signed [lav_pkg::VW-1:0] w_a;
    logic signed [lav_pkg::BW-1:0] w_b;
    logic [1:0]                    w_nterm, w_nres, w_p, w_q;
    logic                          w_tlast, w_mac_done;

    logic [1:0]                    r_row;
    logic                          r_o_valid, r_o_last;
    logic [3*lav_pkg::CW-1:0]      r_o_data;
    logic [lav_pkg::USERW-1:0]     r_o_user;
    logic                          w_ofree, w_load, w_nstart;

    lav_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_nstart),
        .i_vec     (r_vec),
        .i_min_len (i_min_len),
        .o_sts     (w_nsts),
        .o_vec     (w_nvec)
    );

    always_comb begin
        w_p = (r_j == 2'd2) ? 2'd0 : r_j + 1'b1;
        w_q = (w_p == 2'd2) ? 2'd0 : w_p + 1'b1;
        w_a = '0;
        w_b = '0;
        unique case (r_job)
            lav_pkg::J_DOT: begin
                w_nterm = 2'd3;
                w_nres  = 2'd1;
                w_a     = lav_pkg::VW'(r_up[r_k]);
                w_b     = lav_pkg::BW'(r_f[r_k]);
            end
            lav_pkg::J_W: begin
                w_nterm = 2'd1;
                w_nres  = 2'd3;
                w_b     = lav_pkg::BW'(r_f[r_j]);
                priority case (r_try)
                    lav_pkg::T_WORLD:  w_a = r_dot;
                    lav_pkg::T_AXIS_Y: w_a = lav_pkg::VW'(r_f[1]);
                    default:           w_a = lav_pkg::VW'(r_f[2]);
                endcase
            end
            lav_pkg::J_CROSS: begin
                w_nterm = 2'd2;
                w_nres  = 2'd3;
                if (r_k == 2'd0) begin
                    w_a = lav_pkg::VW'(r_u[w_p]);
                    w_b = lav_pkg::BW'(r_f[w_q]);
                end else begin
                    w_a = -lav_pkg::VW'(r_u[w_q]);
                    w_b = lav_pkg::BW'(r_f[w_p]);
                end
            end
            lav_pkg::J_TRANS: begin
                w_nterm = 2'd3;
                w_nres  = 2'd3;
                w_a     = lav_pkg::VW'(r_eye[r_k]);
                priority case (r_j)
                    2'd0:    w_b = lav_pkg::BW'(r_r[r_k]);
                    2'd1:    w_b = lav_pkg::BW'(r_u[r_k]);
                    default: w_b = lav_pkg::BW'(r_f[r_k]);
                endcase
            end
        endcase
    end

    assign w_tlast    = (r_k == w_nterm - 2'd1);
    assign w_mac_done = r_iss_done && !r_pv;
    assign w_sum      = (r_pfirst ? '0 : r_acc) + lav_pkg::SW'(r_prod);
    assign w_rnd      = (w_sum + HALF) >>> lav_pkg::FRAC_BITS;
    assign w_ofree    = !r_o_valid || i_ready;

    always_comb begin
        priority if (r_try == lav_pkg::T_WORLD) begin
            w_base = lav_pkg::SW'(r_up[r_pj]);
        end else if ((r_try == lav_pkg::T_AXIS_Y) && (r_pj == 2'd1)) begin
            w_base = ONE;
        end else if ((r_try == lav_pkg::T_AXIS_Z) && (r_pj == 2'd2)) begin
            w_base = ONE;
        end else begin
            w_base = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lav_pkg::B_IDLE:    if (i_avail) n_state = lav_pkg::B_NF_GO;
            lav_pkg::B_NF_GO:   n_state = lav_pkg::B_NF_WAIT;
            lav_pkg::B_NF_WAIT: begin
                if (w_nsts.done) n_state = w_nsts.ok ? lav_pkg::B_MAC : lav_pkg::B_ERR;
            end
            lav_pkg::B_MAC: begin
                if (w_mac_done && (r_job == lav_pkg::J_W)) begin
                    n_state = lav_pkg::B_NU_GO;
                end else if (w_mac_done && (r_job == lav_pkg::J_TRANS)) begin
                    n_state = lav_pkg::B_EMIT;
                end
            end
            lav_pkg::B_NU_GO:   n_state = lav_pkg::B_NU_WAIT;
            lav_pkg::B_NU_WAIT: begin
                if (w_nsts.done) begin
                    n_state = (w_nsts.ok || (r_try != lav_pkg::T_AXIS_Z)) ? lav_pkg::B_MAC
                                                                          : lav_pkg::B_ERR;
                end
            end
            lav_pkg::B_EMIT: if (w_ofree && (r_row == lav_pkg::ROW_TRANS)) n_state = lav_pkg::B_IDLE;
            lav_pkg::B_ERR:  if (w_ofree) n_state = lav_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == lav_pkg::B_IDLE) && i_avail;
        w_nstart = (r_state == lav_pkg::B_NF_GO) || (r_state == lav_pkg::B_NU_GO);
        w_load   = ((r_state == lav_pkg::B_EMIT) || (r_state == lav_pkg::B_ERR)) && w_ofree;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lav_pkg::B_IDLE;
            r_o_valid  <= 1'b0;
            r_iss_done <= 1'b0;
            r_pv       <= 1'b0;
            r_j        <= '0;
            r_k        <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            r_pv <= (r_state == lav_pkg::B_MAC) && !r_iss_done;
            if (w_mac_done) begin
                r_iss_done <= 1'b0;
                r_j        <= '0;
                r_k        <= '0;
            end else if ((r_state == lav_pkg::B_MAC) && !r_iss_done) begin
                if (w_tlast) begin
                    r_k <= '0;
                    if (r_j == w_nres - 2'd1) begin
                        r_iss_done <= 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 3; k++) begin
                r_eye[k] <= i_item.eye[k];
                r_up[k]  <= i_item.up[k];
                r_vec[k] <= lav_pkg::VW'($signed(i_item.dir[k]));
            end
        end

        if ((r_state == lav_pkg::B_NF_WAIT) && w_nsts.done) begin
            r_f   <= w_nvec;
            r_job <= lav_pkg::J_DOT;
            r_try <= lav_pkg::T_WORLD;
        end

        if ((r_state == lav_pkg::B_NU_WAIT) && w_nsts.done) begin
            if (w_nsts.ok) begin
                r_u   <= w_nvec;
                r_job <= lav_pkg::J_CROSS;
            end else begin
                r_job <= lav_pkg::J_W;
                r_try <= (r_try == lav_pkg::T_WORLD) ? lav_pkg::T_AXIS_Y : lav_pkg::T_AXIS_Z;
            end
        end

        if ((r_state == lav_pkg::B_MAC) && w_mac_done) begin
            if (r_job == lav_pkg::J_DOT) begin
                r_job <= lav_pkg::J_W;
            end else if (r_job == lav_pkg::J_CROSS) begin
                r_job <= lav_pkg::J_TRANS;
            end
        end

        if ((r_state == lav_pkg::B_MAC) && !r_iss_done) begin
            r_prod   <= w_a * w_b;
            r_pfirst <= (r_k == 2'd0);
            r_plast  <= w_tlast;
            r_pj     <= r_j;
        end

        if (r_pv) begin
            r_acc <= w_sum;
            if (r_plast) begin
                unique case (r_job)
                    lav_pkg::J_DOT:   r_dot       <= lav_pkg::VW'(w_rnd);
                    lav_pkg::J_W:     r_vec[r_pj] <= lav_pkg::VW'(w_base - w_rnd);
                    lav_pkg::J_CROSS: r_r[r_pj]   <= sat32(w_rnd);
                    lav_pkg::J_TRANS: r_t[r_pj]   <= sat32(-w_rnd);
                endcase
            end
        end

        if (r_state == lav_pkg::B_IDLE) begin
            r_row <= '0;
        end

        if (w_load) begin
            if (r_state == lav_pkg::B_ERR) begin
                r_o_data <= '0;
                r_o_user <= {1'b1, 2'd0};
                r_o_last <= 1'b1;
            end else begin
                if (r_row == lav_pkg::ROW_TRANS) begin
                    r_o_data <= {r_t[2], r_t[1], r_t[0]};
                end else begin
                    r_o_data <= {lav_pkg::CW'(r_f[r_row]), lav_pkg::CW'(r_u[r_row]), r_r[r_row]};
                end
                r_o_user <= {1'b0, r_row};
                r_o_last <= (r_row == lav_pkg::ROW_TRANS);
                r_row    <= r_row + 1'b1;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_user  = r_o_user;
    assign o_last  = r_o_last;

endmodule

/* hdl/look_at_view_matrix.sv */
// Left-handed look-at view matrix in signed Q16.16.
// Input stream: one item per camera, tdata holds eye, target and world-up
// (x, y, z each). Output stream: four rows per item, row_index 0..2 carry the
// basis rows (right, up, forward entries), row 3 the translation row; tlast
// marks row 3. Degenerate input yields one item with status set, all other
// fields zero, tlast high.
// Config channel: one write sets min_length (17 bits); write only while idle.
// Each normalization runs on one shared unit: squaring, 32 root steps and a
// bit-serial divide per component; a vector that fails stops after the root
// check. The multiply-accumulate sequencer follows, then the rows are emitted.
// Each up-vector fallback (Y axis, then Z axis) reruns the up normalization.
// Throughput is one item per back-end run; the front queue keeps taking items
// meanwhile until it is full.
// Reset clears the queue, the sequencer and the output register; min_length
// returns to 1. When the receiver stalls, the output item holds and the back
// end waits; the queue keeps accepting until full.
module look_at_view_matrix #(
    parameter int QUEUE_DEPTH = lav_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [9*lav_pkg::CW-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // col_right, col_up, col_forward
    output logic [3*lav_pkg::CW-1:0]        m_axis_tdata,
    // row_index, status
    output logic [lav_pkg::USERW-1:0]       m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lav_pkg::MINW-1:0]        i_cfg_data
);

    logic [lav_pkg::MINW-1:0] r_min_len;
    logic                     w_avail, w_pop;
    lav_pkg::t_item           w_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= lav_pkg::MIN_LEN_RST;
        end else if (i_cfg_valid) begin
            r_min_len <= i_cfg_data;
        end
    end

    lav_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_item)
    );

    lav_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_avail   (w_avail),
        .o_pop     (w_pop),
        .i_item    (w_item),
        .i_min_len (r_min_len),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tlast && (m_axis_tuser[1:0] == 2'd0)))
        else $error("error item not alone");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[2])
            |-> (m_axis_tlast == (m_axis_tuser[1:0] == lav_pkg::ROW_TRANS)))
        else $error("tlast not on translation row");

    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
